[design/erfc_pkg.sv]
package erfc_pkg;

	// frame storage
	localparam int MAX_FRAME_BYTES = 11;
	localparam int FB_IDX_W = $clog2(MAX_FRAME_BYTES);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_BYTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT       = 2'd2;

	// configuration reset values
	localparam logic [7:0] CONTROL_BYTE_RST = 8'd2;
	localparam logic [3:0] LENGTH_RST       = 4'd6;

	// item modes
	localparam logic MODE_DATA = 1'b0;
	localparam logic MODE_EOF  = 1'b1;

	// error codes
	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
	localparam logic [2:0] ERR_SIZE     = 3'd2;
	localparam logic [2:0] ERR_CONTROL  = 3'd3;
	localparam logic [2:0] ERR_CHECKSUM = 3'd4;

	// payload layouts
	localparam logic [2:0] LAYOUT_POSITION = 3'd0;
	localparam logic [2:0] LAYOUT_TURNS    = 3'd1;
	localparam logic [2:0] LAYOUT_ID       = 3'd2;
	localparam logic [2:0] LAYOUT_FULL     = 3'd3;
	localparam logic [2:0] LAYOUT_EEPROM   = 3'd4;

	// byte counter saturates here
	localparam logic [3:0] COUNT_MAX = 4'd15;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  error_code;
		logic [7:0]  status_byte;
		logic [23:0] position;
		logic [23:0] turns;
		logic [7:0]  encoder_id;
		logic [7:0]  alarm_byte;
		logic [7:0]  eeprom_address;
		logic [7:0]  eeprom_data;
	} out_item_t;

endpackage

[design/encoder_response_frame_checker.sv]
// Encoder response frame checker.
// Input channel (in_valid / in_stall / in_item): one item per received byte
// (mode data), then one end-of-frame item (mode end of frame). Data items
// produce no result; each end-of-frame item produces exactly one result.
// Output channel (out_valid / out_stall / out_item): error code of the frame
// plus every held field (status, position, turns, id, alarm, EEPROM address
// and data); held fields change only on a frame that passes all checks.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (0 control byte, 1 expected length, 2 payload layout); write
// only while no frame is in progress and no result is pending.
// Result: registered, valid in the cycle after the end-of-frame item is taken.
// Input: one item per cycle while in_stall is low; the byte count, running
// XOR and byte store are updated in the cycle the item is taken.
// Stall: while a result waits on out_stall, data items are still taken;
// an end-of-frame item is held off until the waiting result is taken.
// Reset: counters, XOR, held fields and registers return to their defaults
// and the output is empty; the byte store needs no clearing.
module encoder_response_frame_checker
	import erfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0]  control_byte_q;
	logic [3:0]  length_q;
	logic [2:0]  layout_q;

	logic [3:0]  byte_count_q;
	logic [7:0]  running_xor_q;
	logic [7:0]  frame_bytes_q [MAX_FRAME_BYTES];

	logic        out_valid_q;
	logic [2:0]  error_q;
	logic [7:0]  held_status_q;
	logic [23:0] held_position_q;
	logic [23:0] held_turns_q;
	logic [7:0]  held_id_q;
	logic [7:0]  held_alarm_q;
	logic [7:0]  held_eeprom_address_q;
	logic [7:0]  held_eeprom_data_q;

	logic        accept;
	logic        accept_byte;
	logic        accept_eof;
	logic [2:0]  error_d;

	// hold off an end of frame only while a result still waits
	assign in_stall    = out_valid_q && out_stall && (in_item.mode == MODE_EOF);
	assign accept      = in_valid && !in_stall;
	assign accept_byte = accept && (in_item.mode == MODE_DATA);
	assign accept_eof  = accept && (in_item.mode == MODE_EOF);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_byte_q <= CONTROL_BYTE_RST;
			length_q       <= LENGTH_RST;
			layout_q       <= LAYOUT_POSITION;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONTROL_BYTE: control_byte_q <= cfg_data;
				CFG_LENGTH:       length_q       <= cfg_data[3:0];
				CFG_LAYOUT:       layout_q       <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// count bytes and fold them into the checksum; clear at end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			running_xor_q <= '0;
		end else if (accept_eof) begin
			byte_count_q  <= '0;
			running_xor_q <= '0;
		end else if (accept_byte) begin
			running_xor_q <= running_xor_q ^ in_item.rx_byte;
			if (byte_count_q != COUNT_MAX) begin
				byte_count_q <= byte_count_q + 4'd1;
			end
		end
	end

	// store bytes that fit the frame buffer; drop the rest
	always_ff @(posedge clk) begin
		if (accept_byte && (byte_count_q < 4'(MAX_FRAME_BYTES))) begin
			frame_bytes_q[byte_count_q[FB_IDX_W-1:0]] <= in_item.rx_byte;
		end
	end

	// check the frame in priority order
	always_comb begin
		priority if (byte_count_q == '0) begin
			error_d = ERR_TIMEOUT;
		end else if (byte_count_q != length_q) begin
			error_d = ERR_SIZE;
		end else if (frame_bytes_q[0] != control_byte_q) begin
			error_d = ERR_CONTROL;
		end else if (running_xor_q != '0) begin
			error_d = ERR_CHECKSUM;
		end else begin
			error_d = ERR_OK;
		end
	end

	// result valid and error code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			error_q     <= ERR_OK;
		end else begin
			if (accept_eof) begin
				out_valid_q <= 1'b1;
				error_q     <= error_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// update the held fields of the configured layout on a good frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_status_q         <= '0;
			held_position_q       <= '0;
			held_turns_q          <= '0;
			held_id_q             <= '0;
			held_alarm_q          <= '0;
			held_eeprom_address_q <= '0;
			held_eeprom_data_q    <= '0;
		end else if (accept_eof && (error_d == ERR_OK)) begin
			unique case (layout_q)
				LAYOUT_POSITION: begin
					held_status_q   <= frame_bytes_q[1];
					held_position_q <= {frame_bytes_q[4], frame_bytes_q[3], frame_bytes_q[2]};
				end
				LAYOUT_TURNS: begin
					held_status_q <= frame_bytes_q[1];
					held_turns_q  <= {frame_bytes_q[4], frame_bytes_q[3], frame_bytes_q[2]};
				end
				LAYOUT_ID: begin
					held_id_q <= frame_bytes_q[1];
				end
				LAYOUT_FULL: begin
					held_status_q   <= frame_bytes_q[1];
					held_position_q <= {frame_bytes_q[4], frame_bytes_q[3], frame_bytes_q[2]};
					held_id_q       <= frame_bytes_q[5];
					held_turns_q    <= {frame_bytes_q[8], frame_bytes_q[7], frame_bytes_q[6]};
					held_alarm_q    <= frame_bytes_q[9];
				end
				LAYOUT_EEPROM: begin
					held_eeprom_address_q <= frame_bytes_q[1];
					held_eeprom_data_q    <= frame_bytes_q[2];
				end
				default: ;
			endcase
		end
	end

	// drive the result item
	assign out_valid               = out_valid_q;
	assign out_item.error_code     = error_q;
	assign out_item.status_byte    = held_status_q;
	assign out_item.position       = held_position_q;
	assign out_item.turns          = held_turns_q;
	assign out_item.encoder_id     = held_id_q;
	assign out_item.alarm_byte     = held_alarm_q;
	assign out_item.eeprom_address = held_eeprom_address_q;
	assign out_item.eeprom_data    = held_eeprom_data_q;

`ifndef NO_ASSERTIONS
	// an accepted end of frame always yields a result next cycle
	a_eof_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept_eof |=> out_valid)
		else $error("end of frame gave no result");

	// counter and checksum restart after end of frame
	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept_eof |=> (byte_count_q == '0) && (running_xor_q == '0))
		else $error("frame state not cleared after end of frame");

	// an empty frame reports a timeout
	a_empty_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		accept_eof && (byte_count_q == '0) |=> (error_q == ERR_TIMEOUT))
		else $error("empty frame not reported as timeout");

	// held fields move only on an accepted end of frame
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept_eof |=> $stable(held_status_q) && $stable(held_position_q)
			&& $stable(held_turns_q) && $stable(held_id_q))
		else $error("held field changed without end of frame");

	// a failed frame leaves the held fields untouched
	a_bad_frame_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept_eof && (error_d != ERR_OK) |=> $stable(held_position_q)
			&& $stable(held_eeprom_data_q) && $stable(held_alarm_q))
		else $error("held field changed on a failed frame");
`endif

endmodule
